### hdl/i2cadc_pkg.sv
// Package for the I2C converter read master: step codes, beat and configuration types.
package i2cadc_pkg;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd72;
    localparam logic [7:0] PHASE_TICKS_RST    = 8'd5;
    localparam logic [7:0] CTRL_BYTE_BASE     = 8'h40;

    // Register indexes on the configuration port.
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_SH       = 5'd1,
        ST_SL       = 5'd2,
        ST_SC       = 5'd3,
        ST_RP       = 5'd4,
        ST_RH       = 5'd5,
        ST_RL       = 5'd6,
        ST_RC       = 5'd7,
        ST_B0_LOW   = 5'd8,
        ST_B0_HIGH  = 5'd9,
        ST_B0_ACKL  = 5'd10,
        ST_B0_ACKH  = 5'd11,
        ST_B1_LOW   = 5'd12,
        ST_B1_HIGH  = 5'd13,
        ST_B1_ACKL  = 5'd14,
        ST_B1_ACKH  = 5'd15,
        ST_B2_LOW   = 5'd16,
        ST_B2_HIGH  = 5'd17,
        ST_B2_ACKL  = 5'd18,
        ST_B2_ACKH  = 5'd19,
        ST_RDL      = 5'd20,
        ST_RDH      = 5'd21,
        ST_NL       = 5'd22,
        ST_NH       = 5'd23,
        ST_PL       = 5'd24,
        ST_PH       = 5'd25,
        ST_PE       = 5'd26
    } t_step;

    typedef struct packed {
        logic       begin_read;
        logic [1:0] channel;
        logic       sda_level;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] sample;
    } t_out;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] phase_ticks;
    } t_cfg;

endpackage

### hdl/i2cadc_seq.sv
// Bus sequencer: holds the step state and advances it by one tick per accepted beat.
module i2cadc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  i2cadc_pkg::t_in     i_in,
    input  i2cadc_pkg::t_cfg    i_cfg,
    output i2cadc_pkg::t_out    o_res
);
    import i2cadc_pkg::*;

    t_step      r_step,   n_step;
    logic [2:0] r_bits,   n_bits;
    logic [7:0] r_shift,  n_shift;
    logic [7:0] r_timer,  n_timer;
    logic [7:0] r_sample, n_sample;
    logic [1:0] r_chan,   n_chan;

    logic [7:0] limit;
    logic       expired;
    logic [4:0] byte_off;
    logic [1:0] which;
    logic [7:0] addr_byte;
    logic       scl, rel, busy, done;

    assign limit    = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
    assign expired  = ({1'b0, r_timer} + 9'd1) >= {1'b0, limit};
    assign byte_off = r_step - ST_B0_LOW;
    assign which    = byte_off[3:2];
    assign addr_byte = {i_cfg.device_address, 1'b0};

    // Next state.
    always_comb begin
        n_step   = r_step;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_timer  = r_timer;
        n_sample = r_sample;
        n_chan   = r_chan;
        done     = 1'b0;
        unique case (r_step) inside
            ST_IDLE: begin
                if (i_in.begin_read) begin
                    n_chan  = i_in.channel;
                    n_step  = ST_SH;
                    n_timer = 8'd0;
                end
            end
            [ST_B0_LOW:ST_B2_ACKH]: begin
                if (r_step[1:0] == 2'd3) begin
                    // Acknowledge phase: SCL held high until the target pulls SDA low.
                    if (expired && !i_in.sda_level) begin
                        n_timer = 8'd0;
                        if (which == 2'd0) begin
                            n_shift = CTRL_BYTE_BASE | {6'd0, r_chan};
                            n_bits  = 3'd0;
                            n_step  = ST_B1_LOW;
                        end else if (which == 2'd1) begin
                            n_step = ST_RP;
                        end else begin
                            n_shift = 8'd0;
                            n_bits  = 3'd0;
                            n_step  = ST_RDL;
                        end
                    end else if (r_timer != 8'hFF) begin
                        n_timer = r_timer + 8'd1;
                    end
                end else if (!expired) begin
                    n_timer = r_timer + 8'd1;
                end else begin
                    n_timer = 8'd0;
                    case (r_step[1:0])
                        2'd0: n_step = t_step'({r_step[4:2], 2'd1});
                        2'd1: begin
                            if (r_bits == 3'd7) begin
                                n_bits = 3'd0;
                                n_step = t_step'({r_step[4:2], 2'd2});
                            end else begin
                                n_bits  = r_bits + 3'd1;
                                n_shift = {r_shift[6:0], 1'b0};
                                n_step  = t_step'({r_step[4:2], 2'd0});
                            end
                        end
                        default: n_step = t_step'({r_step[4:2], 2'd3});
                    endcase
                end
            end
            ST_SH, ST_SL, ST_SC, ST_RP, ST_RH, ST_RL, ST_RC,
            ST_RDL, ST_RDH, ST_NL, ST_NH, ST_PL, ST_PH, ST_PE: begin
                if (!expired) begin
                    n_timer = r_timer + 8'd1;
                end else begin
                    n_timer = 8'd0;
                    unique case (r_step)
                        ST_SH: n_step = ST_SL;
                        ST_SL: n_step = ST_SC;
                        ST_SC: begin
                            n_shift = addr_byte;
                            n_bits  = 3'd0;
                            n_step  = ST_B0_LOW;
                        end
                        ST_RP: n_step = ST_RH;
                        ST_RH: n_step = ST_RL;
                        ST_RL: n_step = ST_RC;
                        ST_RC: begin
                            n_shift = addr_byte | 8'd1;
                            n_bits  = 3'd0;
                            n_step  = ST_B2_LOW;
                        end
                        ST_RDL: n_step = ST_RDH;
                        ST_RDH: begin
                            n_shift = {r_shift[6:0], i_in.sda_level};
                            if (r_bits == 3'd7) begin
                                n_bits   = 3'd0;
                                n_sample = {r_shift[6:0], i_in.sda_level};
                                n_step   = ST_NL;
                            end else begin
                                n_bits = r_bits + 3'd1;
                                n_step = ST_RDL;
                            end
                        end
                        ST_NL: n_step = ST_NH;
                        ST_NH: n_step = ST_PL;
                        ST_PL: n_step = ST_PH;
                        ST_PH: n_step = ST_PE;
                        default: begin
                            done   = 1'b1;
                            n_step = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_step  = ST_IDLE;
                n_timer = 8'd0;
            end
        endcase
    end

    // Bus levels for the current step.
    always_comb begin
        scl  = 1'b1;
        rel  = 1'b1;
        busy = 1'b1;
        unique case (r_step) inside
            [ST_B0_LOW:ST_B2_ACKH]: begin
                scl = r_step[0];
                rel = r_step[1] ? 1'b1 : r_shift[7];
            end
            ST_SH, ST_RH, ST_RDH, ST_NH, ST_PE: begin
                scl = 1'b1;
                rel = 1'b1;
            end
            ST_SL, ST_RL, ST_PH: begin
                scl = 1'b1;
                rel = 1'b0;
            end
            ST_SC, ST_RC, ST_PL: begin
                scl = 1'b0;
                rel = 1'b0;
            end
            ST_RP, ST_RDL, ST_NL: begin
                scl = 1'b0;
                rel = 1'b1;
            end
            default: begin
                scl  = 1'b1;
                rel  = 1'b1;
                busy = 1'b0;
            end
        endcase
    end

    assign o_res = '{scl_level: scl, sda_release: rel, busy_res: busy,
                     done_res: done, sample: n_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_bits   <= 3'd0;
            r_shift  <= 8'd0;
            r_timer  <= 8'd0;
            r_sample <= 8'd0;
            r_chan   <= 2'd0;
        end else if (i_adv) begin
            r_step   <= n_step;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_timer  <= n_timer;
            r_sample <= n_sample;
            r_chan   <= n_chan;
        end
    end

endmodule

### hdl/i2c_adc_read_master_core.sv
// Top level of the I2C converter read master: configuration, handshakes and result register.
//
//  Channel  Direction  Handshake                  Beat
//  in       input      i_in_valid / o_in_ready    t_in  (begin_read, channel, sda_level)
//  out      output     o_out_valid / i_out_ready  t_out (scl, sda release, busy, done, sample)
//  cfg      input      i_cfg_we                   index i_cfg_index, data i_cfg_data
//
// One input beat is one bus tick; its result lands in the output register on the same
// edge that accepts it, so a beat can be accepted every cycle while the output is not stalled.
// The result beat appears in the cycle after the input beat, held by the single result register.
// Reset is synchronous; it returns the sequencer to idle and empties the result register.
// A stall on the output side holds the result, and the input is taken only when the
// result register is empty or being emptied in that cycle.
module i2c_adc_read_master_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  i2cadc_pkg::t_in     i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cadc_pkg::t_out    o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import i2cadc_pkg::*;

    t_cfg r_cfg;
    t_out r_out;
    t_out res;
    logic r_out_valid;
    logic accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DEVICE_ADDRESS_RST;
            r_cfg.phase_ticks    <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[6:0];
                CFG_PHASE_TICKS:    r_cfg.phase_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2cadc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> o_out.busy_res)
        else $error("done beat without busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.busy_res |-> o_out.scl_level && o_out.sda_release)
        else $error("bus not released while idle");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("stalled result lost");

endmodule
